// File: design/msp_pkg.sv
`default_nettype none

package msp_pkg;

  localparam logic [7:0] SOX_BYTE      = 8'hF0;
  localparam logic [7:0] EOX_BYTE      = 8'hF7;
  localparam logic [7:0] REALTIME_BASE = 8'hF8;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [2:0] {
    REG_VENDOR_ONE   = 3'd0,
    REG_VENDOR_TWO   = 3'd1,
    REG_VENDOR_THREE = 3'd2,
    REG_ACK_CODE     = 3'd3,
    REG_MAIN_CODE    = 3'd4,
    REG_LOADER_CODE  = 3'd5,
    REG_BLOCK_CODE   = 3'd6,
    REG_IMAGE_CODE   = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    P_START = 5'd0,
    P_VEND1 = 5'd1,
    P_VEND2 = 5'd2,
    P_VEND3 = 5'd3,
    P_CMD   = 5'd4,
    P_RAW0  = 5'd5,
    P_RAW1  = 5'd6,
    P_RAW2  = 5'd7,
    P_RAW3  = 5'd8,
    P_RAW4  = 5'd9,
    P_LEN   = 5'd10,
    P_ADDR1 = 5'd11,
    P_ADDR2 = 5'd12,
    P_ADDR3 = 5'd13,
    P_ADDR4 = 5'd14,
    P_DATA  = 5'd15,
    P_CSUM  = 5'd16,
    P_END   = 5'd17
  } parse_state_t;

endpackage

`default_nettype wire

// File: design/msp_byte_if.sv
`default_nettype none

interface msp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: design/msp_result_if.sv
`default_nettype none

interface msp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  byte_index;
  logic [7:0]  byte_value;
  logic [6:0]  command;
  logic [27:0] block_address;
  logic [6:0]  block_length;

  modport source (
    output valid, output kind, output byte_index, output byte_value,
    output command, output block_address, output block_length,
    input ready
  );
  modport sink (
    input valid, input kind, input byte_index, input byte_value,
    input command, input block_address, input block_length,
    output ready
  );
endinterface

`default_nettype wire

// File: design/midi_sysex_command_parser.sv
`default_nettype none

// MIDI SysEx command parser: takes one MIDI byte per cycle and produces at most one
// result item per byte, registered in the cycle after the byte is accepted. Decoded
// payload bytes (kind 0) are only trustworthy once a completion item (kind 1, on the
// closing F7) follows; a message with a bad checksum or an abort simply never
// completes. The single output register sets the rate: midi.ready is high whenever that
// register is empty or being taken in the same cycle, so a byte every cycle flows through.
// Configuration registers are to be written only while the parser is idle.
module midi_sysex_command_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [2:0]   wr_index,
  input  wire logic [6:0]   wr_data,
  msp_byte_if.sink          midi,
  msp_result_if.source      result
);

  logic [6:0] vendor_one, vendor_two, vendor_three;
  logic [6:0] ack_code, main_code, loader_code, block_code, image_code;

  logic                  outer_mode, outer_mode_next;
  msp_pkg::parse_state_t parse_state, parse_state_next;
  logic [6:0]            command_reg, command_reg_next;
  logic [6:0]            running_xor, running_xor_next;
  logic [6:0]            length_reg, length_reg_next;
  logic [27:0]           address_reg, address_reg_next;
  logic [2:0]            group_count, group_count_next;
  logic [6:0]            received_count, received_count_next;
  logic [6:0]            high_bits, high_bits_next;

  logic       emit;
  logic       emit_kind;
  logic [6:0] emit_index;
  logic [7:0] emit_value;

  logic        res_valid;
  logic        res_kind;
  logic [6:0]  res_index;
  logic [7:0]  res_value;
  logic [6:0]  res_command;
  logic [27:0] res_address;
  logic [6:0]  res_length;

  logic       accept;
  logic [7:0] b;
  logic [6:0] b7;
  logic       is_rt, is_sox, is_eox, do_parse, is_data;
  logic [6:0] received_inc;

  assign midi.ready = !res_valid || result.ready;
  assign accept     = midi.valid && midi.ready;
  assign b          = midi.in_byte;
  assign b7         = b[6:0];
  assign is_rt      = b >= msp_pkg::REALTIME_BASE;
  assign is_sox     = b == msp_pkg::SOX_BYTE;
  assign is_eox     = b == msp_pkg::EOX_BYTE;
  assign do_parse   = outer_mode && !is_rt && (!b[7] || is_eox);
  assign is_data    = do_parse && !b[7];

  // count after this byte, for the end-of-payload test
  assign received_inc = (group_count == 3'd0) ? received_count : received_count + 7'd1;

  // next state
  always_comb begin
    outer_mode_next  = outer_mode;
    parse_state_next = parse_state;
    if (is_rt) begin
      outer_mode_next = outer_mode;
    end else if (is_sox) begin
      outer_mode_next  = 1'b1;
      parse_state_next = msp_pkg::P_VEND1;
    end else if (outer_mode && b[7] && !is_eox) begin
      outer_mode_next  = 1'b0;
      parse_state_next = msp_pkg::P_START;
    end else if (do_parse) begin
      if (is_eox) begin
        parse_state_next = msp_pkg::P_START;
      end else begin
        unique case (parse_state) inside
          msp_pkg::P_VEND1: begin
            if (b7 != vendor_one) parse_state_next = msp_pkg::P_START;
            else if (b7 == 7'd0)  parse_state_next = msp_pkg::P_VEND2;
            else                  parse_state_next = msp_pkg::P_CMD;
          end
          msp_pkg::P_VEND2:
            parse_state_next = (b7 == vendor_two) ? msp_pkg::P_VEND3 : msp_pkg::P_START;
          msp_pkg::P_VEND3:
            parse_state_next = (b7 == vendor_three) ? msp_pkg::P_CMD : msp_pkg::P_START;
          msp_pkg::P_CMD: begin
            if (b7 == ack_code || b7 == main_code || b7 == loader_code)
              parse_state_next = msp_pkg::P_END;
            else if (b7 == block_code)
              parse_state_next = msp_pkg::P_LEN;
            else if (b7 == image_code)
              parse_state_next = msp_pkg::P_RAW0;
            else
              parse_state_next = msp_pkg::P_START;
          end
          msp_pkg::P_RAW0: parse_state_next = msp_pkg::P_RAW1;
          msp_pkg::P_RAW1: parse_state_next = msp_pkg::P_RAW2;
          msp_pkg::P_RAW2: parse_state_next = msp_pkg::P_RAW3;
          msp_pkg::P_RAW3: parse_state_next = msp_pkg::P_RAW4;
          msp_pkg::P_RAW4: parse_state_next = msp_pkg::P_END;
          msp_pkg::P_LEN:   parse_state_next = msp_pkg::P_ADDR1;
          msp_pkg::P_ADDR1: parse_state_next = msp_pkg::P_ADDR2;
          msp_pkg::P_ADDR2: parse_state_next = msp_pkg::P_ADDR3;
          msp_pkg::P_ADDR3: parse_state_next = msp_pkg::P_ADDR4;
          msp_pkg::P_ADDR4: parse_state_next = msp_pkg::P_DATA;
          msp_pkg::P_DATA:
            parse_state_next = (received_inc >= length_reg) ? msp_pkg::P_CSUM
                                                            : msp_pkg::P_DATA;
          msp_pkg::P_CSUM:
            parse_state_next = (running_xor == b7) ? msp_pkg::P_END : msp_pkg::P_START;
          default: parse_state_next = msp_pkg::P_START;
        endcase
      end
    end
  end

  // message registers and result
  always_comb begin
    command_reg_next    = command_reg;
    running_xor_next    = running_xor;
    length_reg_next     = length_reg;
    address_reg_next    = address_reg;
    group_count_next    = group_count;
    received_count_next = received_count;
    high_bits_next      = high_bits;
    emit                = 1'b0;
    emit_kind           = msp_pkg::KIND_DATA;
    emit_index          = 7'd0;
    emit_value          = 8'd0;
    if (!is_rt && is_sox) begin
      command_reg_next    = 7'd0;
      running_xor_next    = 7'd0;
      length_reg_next     = 7'd0;
      address_reg_next    = 28'd0;
      group_count_next    = 3'd0;
      received_count_next = 7'd0;
      high_bits_next      = 7'd0;
    end else if (is_data) begin
      unique case (parse_state) inside
        msp_pkg::P_CMD: begin
          command_reg_next = b7;
          running_xor_next = running_xor ^ b7;
        end
        msp_pkg::P_LEN: begin
          length_reg_next  = b7;
          running_xor_next = running_xor ^ b7;
          group_count_next = 3'd0;
        end
        msp_pkg::P_ADDR1: begin
          running_xor_next       = running_xor ^ b7;
          address_reg_next[6:0]  = address_reg[6:0] | b7;
        end
        msp_pkg::P_ADDR2: begin
          running_xor_next       = running_xor ^ b7;
          address_reg_next[13:7] = address_reg[13:7] | b7;
        end
        msp_pkg::P_ADDR3: begin
          running_xor_next        = running_xor ^ b7;
          address_reg_next[20:14] = address_reg[20:14] | b7;
        end
        msp_pkg::P_ADDR4: begin
          running_xor_next        = running_xor ^ b7;
          address_reg_next[27:21] = address_reg[27:21] | b7;
        end
        msp_pkg::P_DATA: begin
          running_xor_next = running_xor ^ b7;
          if (group_count == 3'd0) begin
            high_bits_next = b7;
          end else begin
            emit                = 1'b1;
            emit_index          = received_count;
            emit_value          = {high_bits[0], b7};
            received_count_next = received_count + 7'd1;
            high_bits_next      = high_bits >> 1;
          end
          group_count_next = group_count + 3'd1;
        end
        msp_pkg::P_RAW0, msp_pkg::P_RAW1, msp_pkg::P_RAW2,
        msp_pkg::P_RAW3, msp_pkg::P_RAW4: begin
          emit       = 1'b1;
          emit_index = 7'(5'(parse_state - msp_pkg::P_RAW0));
          emit_value = b;
        end
        default: emit = 1'b0;
      endcase
    end else if (do_parse && is_eox && parse_state == msp_pkg::P_END) begin
      emit      = 1'b1;
      emit_kind = msp_pkg::KIND_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_one     <= 7'd0;
      vendor_two     <= 7'd0;
      vendor_three   <= 7'd0;
      ack_code       <= 7'd1;
      main_code      <= 7'd2;
      loader_code    <= 7'd3;
      block_code     <= 7'd4;
      image_code     <= 7'd5;
      outer_mode     <= 1'b0;
      parse_state    <= msp_pkg::P_START;
      command_reg    <= 7'd0;
      running_xor    <= 7'd0;
      length_reg     <= 7'd0;
      address_reg    <= 28'd0;
      group_count    <= 3'd0;
      received_count <= 7'd0;
      high_bits      <= 7'd0;
      res_valid      <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (msp_pkg::cfg_reg_t'(wr_index))
          msp_pkg::REG_VENDOR_ONE:   vendor_one   <= wr_data;
          msp_pkg::REG_VENDOR_TWO:   vendor_two   <= wr_data;
          msp_pkg::REG_VENDOR_THREE: vendor_three <= wr_data;
          msp_pkg::REG_ACK_CODE:     ack_code     <= wr_data;
          msp_pkg::REG_MAIN_CODE:    main_code    <= wr_data;
          msp_pkg::REG_LOADER_CODE:  loader_code  <= wr_data;
          msp_pkg::REG_BLOCK_CODE:   block_code   <= wr_data;
          msp_pkg::REG_IMAGE_CODE:   image_code   <= wr_data;
        endcase
      end
      if (accept) begin
        outer_mode     <= outer_mode_next;
        parse_state    <= parse_state_next;
        command_reg    <= command_reg_next;
        running_xor    <= running_xor_next;
        length_reg     <= length_reg_next;
        address_reg    <= address_reg_next;
        group_count    <= group_count_next;
        received_count <= received_count_next;
        high_bits      <= high_bits_next;
      end
      if (midi.ready) begin
        res_valid <= accept && emit;
      end
    end
  end

  // result payload, loaded with the item that produced it
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_kind    <= emit_kind;
      res_index   <= emit_index;
      res_value   <= emit_value;
      res_command <= command_reg;
      res_address <= address_reg;
      res_length  <= length_reg;
    end
  end

  assign result.valid         = res_valid;
  assign result.kind          = res_kind;
  assign result.byte_index    = res_index;
  assign result.byte_value    = res_value;
  assign result.command       = res_command;
  assign result.block_address = res_address;
  assign result.block_length  = res_length;

endmodule

`default_nettype wire

// File: tb/sv/midi_sysex_command_parser_tb.sv
`default_nettype none

module midi_sysex_command_parser_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic        kind;
    logic [6:0]  byte_index;
    logic [7:0]  byte_value;
    logic [6:0]  command;
    logic [27:0] block_address;
    logic [6:0]  block_length;
  } midi_result_t;

  typedef struct packed {
    logic [7:0]   in_byte;
    bit           has_typed;
    midi_result_t typed;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       wr_en;
  logic [2:0] wr_index;
  logic [6:0] wr_data;

  msp_byte_if   midi_if();
  msp_result_if result_if();

  midi_sysex_command_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .midi     (midi_if),
    .result   (result_if)
  );

  // parser shadow state
  logic [6:0]            cfg_regs [8] = '{7'd0, 7'd0, 7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5};
  bit                    in_message;
  msp_pkg::parse_state_t pstate;
  logic [6:0]            cur_command;
  logic [6:0]            xor_acc;
  logic [6:0]            cur_length;
  logic [27:0]           cur_address;
  logic [2:0]            group_pos;
  logic [6:0]            decoded_count;
  logic [6:0]            pending_high;

  midi_result_t awaited_decodes [$];
  midi_result_t seen;
  midi_result_t want;
  int           bad_items;
  int           items_sent;
  int           cut_countdown;
  bit           gaps_on;
  bit           hold_request;

  // vendor ID 7F (one byte) is loaded before this table
  stim_row_t directed_rows [25] = '{
    '{msp_pkg::SOX_BYTE, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{msp_pkg::EOX_BYTE, 1'b1, '{msp_pkg::KIND_DONE, 7'd0, 8'h00, 7'd1, 28'h0, 7'd0}},
    '{msp_pkg::SOX_BYTE, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h05, 1'b0, '0},
    '{8'h00, 1'b1, '{msp_pkg::KIND_DATA, 7'd0, 8'h00, 7'd5, 28'h0, 7'd0}},
    '{msp_pkg::SOX_BYTE, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{msp_pkg::EOX_BYTE, 1'b1, '{msp_pkg::KIND_DONE, 7'd0, 8'h00, 7'd2, 28'h0, 7'd0}},
    '{msp_pkg::SOX_BYTE, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h04, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h7F, 1'b1, '{msp_pkg::KIND_DATA, 7'd0, 8'hFF, 7'd4, 28'hFFFFFFF, 7'd1}},
    '{8'h05, 1'b0, '0},
    '{msp_pkg::EOX_BYTE, 1'b1,
      '{msp_pkg::KIND_DONE, 7'd0, 8'h00, 7'd4, 28'hFFFFFFF, 7'd1}}
  };

  function automatic bit decode_midi_byte(input logic [7:0] b, output midi_result_t r);
    logic [6:0] d;
    bit         made;
    d = b[6:0];
    made = 1'b0;
    r = '0;
    if (b < msp_pkg::REALTIME_BASE) begin
      if (in_message && b[7] && b != msp_pkg::EOX_BYTE) begin
        in_message = 1'b0;
        pstate = msp_pkg::P_START;
      end
      if (in_message) begin
        if (b == msp_pkg::EOX_BYTE) begin
          if (pstate == msp_pkg::P_END) begin
            made = 1'b1;
            r = '{msp_pkg::KIND_DONE, 7'd0, 8'd0, cur_command, cur_address, cur_length};
          end
          pstate = msp_pkg::P_START;
        end else begin
          case (pstate)
            msp_pkg::P_START: ;
            msp_pkg::P_VEND1: begin
              if (d != cfg_regs[msp_pkg::REG_VENDOR_ONE]) pstate = msp_pkg::P_START;
              else pstate = (d == 7'd0) ? msp_pkg::P_VEND2 : msp_pkg::P_CMD;
            end
            msp_pkg::P_VEND2:
              pstate = (d == cfg_regs[msp_pkg::REG_VENDOR_TWO]) ? msp_pkg::P_VEND3
                                                                 : msp_pkg::P_START;
            msp_pkg::P_VEND3:
              pstate = (d == cfg_regs[msp_pkg::REG_VENDOR_THREE]) ? msp_pkg::P_CMD
                                                                   : msp_pkg::P_START;
            msp_pkg::P_CMD: begin
              cur_command = d;
              xor_acc = xor_acc ^ d;
              if (d == cfg_regs[msp_pkg::REG_ACK_CODE] ||
                  d == cfg_regs[msp_pkg::REG_MAIN_CODE] ||
                  d == cfg_regs[msp_pkg::REG_LOADER_CODE])
                pstate = msp_pkg::P_END;
              else if (d == cfg_regs[msp_pkg::REG_BLOCK_CODE])
                pstate = msp_pkg::P_LEN;
              else if (d == cfg_regs[msp_pkg::REG_IMAGE_CODE])
                pstate = msp_pkg::P_RAW0;
              else
                pstate = msp_pkg::P_START;
            end
            msp_pkg::P_LEN: begin
              cur_length = d;
              xor_acc = xor_acc ^ d;
              group_pos = 3'd0;
              pstate = msp_pkg::P_ADDR1;
            end
            msp_pkg::P_ADDR1, msp_pkg::P_ADDR2, msp_pkg::P_ADDR3, msp_pkg::P_ADDR4: begin
              xor_acc = xor_acc ^ d;
              cur_address = cur_address | ({21'd0, d} << (7 * (pstate - msp_pkg::P_ADDR1)));
              pstate = (pstate == msp_pkg::P_ADDR4) ? msp_pkg::P_DATA
                                                     : msp_pkg::parse_state_t'(pstate + 5'd1);
            end
            msp_pkg::P_RAW0, msp_pkg::P_RAW1, msp_pkg::P_RAW2, msp_pkg::P_RAW3,
            msp_pkg::P_RAW4: begin
              made = 1'b1;
              r = '{msp_pkg::KIND_DATA, 7'(pstate - msp_pkg::P_RAW0), b, cur_command,
                    cur_address, cur_length};
              pstate = (pstate == msp_pkg::P_RAW4) ? msp_pkg::P_END
                                                    : msp_pkg::parse_state_t'(pstate + 5'd1);
            end
            msp_pkg::P_DATA: begin
              xor_acc = xor_acc ^ d;
              if (group_pos == 3'd0) begin
                pending_high = d;
              end else begin
                made = 1'b1;
                r = '{msp_pkg::KIND_DATA, decoded_count, {pending_high[0], d}, cur_command,
                      cur_address, cur_length};
                decoded_count = decoded_count + 7'd1;
                pending_high = pending_high >> 1;
              end
              if (decoded_count >= cur_length) pstate = msp_pkg::P_CSUM;
              group_pos = group_pos + 3'd1;
            end
            msp_pkg::P_CSUM: pstate = (xor_acc == d) ? msp_pkg::P_END : msp_pkg::P_START;
            default: pstate = msp_pkg::P_START;
          endcase
        end
      end else if (b == msp_pkg::SOX_BYTE) begin
        in_message = 1'b1;
        cur_command = '0;
        xor_acc = '0;
        cur_length = '0;
        cur_address = '0;
        group_pos = '0;
        decoded_count = '0;
        pending_high = '0;
        pstate = msp_pkg::P_VEND1;
      end
    end
    return made;
  endfunction

  function automatic string show(input midi_result_t r);
    return $sformatf("kind=%0d idx=%0d val=%02h cmd=%02h addr=%07h len=%0d",
                     r.kind, r.byte_index, r.byte_value, r.command, r.block_address,
                     r.block_length);
  endfunction

  task automatic report_bad(input string what, input string expected, input midi_result_t got);
    bad_items++;
    if (bad_items <= 10) begin
      $display("%s at %0t", what, $realtime);
      $display("  expected %s", expected);
      $display("  actual   %s", show(got));
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic offer_byte(input logic [7:0] b, input bit has_typed, input midi_result_t typed);
    midi_result_t res;
    bit           made;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      midi_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    midi_if.valid <= 1'b1;
    midi_if.in_byte <= b;
    do @(posedge clk); while (!midi_if.ready);
    made = decode_midi_byte(b, res);
    if (has_typed) awaited_decodes.push_back(typed);
    else if (made) awaited_decodes.push_back(res);
    @(negedge clk);
  endtask

  task automatic send(input logic [7:0] b);
    if ($urandom_range(0, 24) == 0)
      offer_byte(8'($urandom_range(msp_pkg::REALTIME_BASE, 8'hFF)), 1'b0, '0);
    if (cut_countdown > 0) begin
      cut_countdown--;
      if (cut_countdown == 0)
        offer_byte($urandom_range(0, 1) ? msp_pkg::EOX_BYTE
                                        : 8'($urandom_range(8'h80, 8'hF6)),
                   1'b0, '0);
    end
    offer_byte(b, 1'b0, '0);
    items_sent++;
  endtask

  task automatic send_random_message(input bit image_only);
    int         pick;
    int         len;
    int         rem;
    int         n;
    int         size_pick;
    logic [6:0] cmd;
    logic [6:0] sum;
    logic [6:0] v;
    pick = image_only ? 45 : $urandom_range(0, 99);
    cut_countdown = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 0;
    if (pick >= 92) begin
      repeat ($urandom_range(1, 6)) send(8'($urandom_range(0, 255)));
    end else begin
      send(msp_pkg::SOX_BYTE);
      if ($urandom_range(0, 29) == 0) begin
        send(8'($urandom_range(0, 127)));
      end else begin
        send({1'b0, cfg_regs[msp_pkg::REG_VENDOR_ONE]});
        if (cfg_regs[msp_pkg::REG_VENDOR_ONE] == 7'd0) begin
          send({1'b0, cfg_regs[msp_pkg::REG_VENDOR_TWO]});
          send({1'b0, cfg_regs[msp_pkg::REG_VENDOR_THREE]});
        end
      end
      if (pick < 40) cmd = cfg_regs[msp_pkg::REG_BLOCK_CODE];
      else if (pick < 60) cmd = cfg_regs[msp_pkg::REG_IMAGE_CODE];
      else if (pick < 66) cmd = cfg_regs[msp_pkg::REG_ACK_CODE];
      else if (pick < 72) cmd = cfg_regs[msp_pkg::REG_MAIN_CODE];
      else if (pick < 78) cmd = cfg_regs[msp_pkg::REG_LOADER_CODE];
      else cmd = 7'($urandom_range(0, 127));
      send({1'b0, cmd});
      sum = cmd;
      if (pick < 40) begin
        size_pick = $urandom_range(0, 29);
        if (size_pick == 0) len = $urandom_range(100, 127);
        else if (size_pick < 4) len = 0;
        else len = $urandom_range(1, 20);
        send(8'(len));
        sum = sum ^ 7'(len);
        repeat (4) begin
          v = 7'($urandom_range(0, 127));
          send({1'b0, v});
          sum = sum ^ v;
        end
        rem = len;
        do begin
          v = 7'($urandom_range(0, 127));
          send({1'b0, v});
          sum = sum ^ v;
          n = (rem < 7) ? rem : 7;
          repeat (n) begin
            v = 7'($urandom_range(0, 127));
            send({1'b0, v});
            sum = sum ^ v;
          end
          rem = rem - n;
        end while (rem > 0);
        if ($urandom_range(0, 15) == 0) sum = sum ^ 7'($urandom_range(1, 127));
        send({1'b0, sum});
      end else if (pick < 60) begin
        repeat (5) send(8'($urandom_range(0, 127)));
      end else if (pick >= 78) begin
        repeat ($urandom_range(0, 4)) send(8'($urandom_range(0, 127)));
      end
      if ($urandom_range(0, 19) == 0) send(8'($urandom_range(0, 127)));
      send(msp_pkg::EOX_BYTE);
      if ($urandom_range(0, 19) == 0) send(8'($urandom_range(0, 127)));
    end
    cut_countdown = 0;
  endtask

  task automatic load_config(input logic [6:0] vendor_one, vendor_two, vendor_three,
                             ack, main_prog, loader, blk_write, img_check);
    logic [6:0]        vals [8];
    msp_pkg::cfg_reg_t idx;
    vals[msp_pkg::REG_VENDOR_ONE] = vendor_one;
    vals[msp_pkg::REG_VENDOR_TWO] = vendor_two;
    vals[msp_pkg::REG_VENDOR_THREE] = vendor_three;
    vals[msp_pkg::REG_ACK_CODE] = ack;
    vals[msp_pkg::REG_MAIN_CODE] = main_prog;
    vals[msp_pkg::REG_LOADER_CODE] = loader;
    vals[msp_pkg::REG_BLOCK_CODE] = blk_write;
    vals[msp_pkg::REG_IMAGE_CODE] = img_check;
    idx = msp_pkg::REG_VENDOR_ONE;
    repeat (8) begin
      wr_en <= 1'b1;
      wr_index <= idx;
      wr_data <= vals[idx];
      @(posedge clk);
      cfg_regs[idx] = vals[idx];
      @(negedge clk);
      idx = idx.next();
    end
    wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    midi_if.valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      seen = '{result_if.kind, result_if.byte_index, result_if.byte_value, result_if.command,
               result_if.block_address, result_if.block_length};
      if (awaited_decodes.size() == 0) begin
        report_bad("unexpected item", "nothing", seen);
      end else begin
        want = awaited_decodes.pop_front();
        if (seen !== want) report_bad("item mismatch", show(want), seen);
      end
    end
  end

  initial begin : result_drain
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    midi_if.valid = 1'b0;
    midi_if.in_byte = '0;
    result_if.ready = 1'b0;
    in_message = 1'b0;
    pstate = msp_pkg::P_START;
    cur_command = '0;
    xor_acc = '0;
    cur_length = '0;
    cur_address = '0;
    group_pos = '0;
    decoded_count = '0;
    pending_high = '0;
    bad_items = 0;
    items_sent = 0;
    cut_countdown = 0;
    gaps_on = 1'b1;
    hold_request = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_config(7'h7F, 7'h00, 7'h00, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5);
    foreach (directed_rows[i])
      offer_byte(directed_rows[i].in_byte, directed_rows[i].has_typed, directed_rows[i].typed);
    wait_drained();

    load_config(7'h00, 7'h00, 7'h00, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5);
    while (items_sent < 400) send_random_message(1'b0);
    wait_drained();

    load_config(7'h00, 7'h7F, 7'h7F, 7'h7F, 7'h00, 7'h55, 7'h2A, 7'h3C);
    while (items_sent < 700) send_random_message(1'b0);
    wait_drained();

    // ack and main program share a code, block write shadows image check
    load_config(7'h41, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'h10, 7'h10, 7'h22, 7'h30, 7'h30);
    while (items_sent < 1000) send_random_message(1'b0);
    wait_drained();

    // long output stall while image checks keep coming
    load_config(7'($urandom_range(1, 127)), 7'h00, 7'h7F, 7'h20, 7'h21, 7'h22, 7'h23, 7'h24);
    hold_request = 1'b1;
    repeat (40) send_random_message(1'b1);
    wait_drained();

    load_config(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    while (items_sent < 1650) send_random_message(1'b0);
    wait_drained();

    gaps_on = 1'b0;
    load_config(7'h00, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'h06, 7'h07, 7'h08, 7'h09, 7'h0A);
    while (items_sent < 1850) send_random_message(1'b0);
    wait_drained();

    if (bad_items == 0 && awaited_decodes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
